// File: sv/dprq_pkg.sv
`timescale 1ns / 1ps

package dprq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int QCNT_W      = 5;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_RUN = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef struct packed {
    logic        [7:0] id;
    logic signed [7:0] prio;
    logic        [7:0] need;
    logic        [7:0] used;
  } entry_t;

endpackage

// File: sv/dprq_mem.sv
`timescale 1ns / 1ps

module dprq_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [dprq_pkg::IDX_W-1:0] waddr,
  input  dprq_pkg::entry_t           wdata,
  input  logic                       re,
  input  logic [dprq_pkg::IDX_W-1:0] raddr,
  output dprq_pkg::entry_t           rdata
);
  import dprq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/dynamic_priority_ready_queue.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// command   in         start && !busy          kind, proc_id, priority_req, slices_needed
// result    out        done (one cycle)        status, ran_id, ran_priority, used_time,
//                                              completed, queue_count
//
// Rejected items and an add to an empty queue raise done in the next cycle.
// An add scans from the tail, moving one entry per cycle.
// A run reads the head, then moves the rest up one entry per cycle and
// reinserts the head on the way unless it has completed. The single
// read and single write port of the entry memory set this pace.
// Reset clears the state, the entry count and done only; done cannot be stalled.

module dynamic_priority_ready_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [7:0]                  proc_id,
  input  logic [6:0]                  priority_req,
  input  logic [7:0]                  slices_needed,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [7:0]                  ran_id,
  output logic signed [7:0]           ran_priority,
  output logic [7:0]                  used_time,
  output logic                        completed,
  output logic [dprq_pkg::QCNT_W-1:0] queue_count
);
  import dprq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_FWD  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] k, k_next;
  logic [IDX_W-1:0] n_rest, n_rest_next;
  logic             ins, ins_next;
  logic             adding, adding_next;
  entry_t           item, item_next;
  logic [CNT_W-1:0] count, count_next;
  logic             done_next;
  logic [1:0]       status_next;
  logic [7:0]       ran_id_next;
  logic signed [7:0] ran_priority_next;
  logic [7:0]       used_time_next;
  logic             completed_next;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  entry_t           new_item, upd;

  dprq_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy        = (state != S_IDLE);
  assign queue_count = QCNT_W'(count);

  always_comb begin
    new_item      = '0;
    new_item.id   = proc_id;
    new_item.prio = $signed({1'b0, priority_req});
    new_item.need = slices_needed;
    new_item.used = '0;

    upd = rdata;
    if (rdata.used != 8'hFF) begin
      upd.used = rdata.used + 8'd1;
    end
    if (rdata.prio != -8'sd128) begin
      upd.prio = rdata.prio - 8'sd1;
    end
  end

  always_comb begin
    state_next        = state;
    k_next            = k;
    n_rest_next       = n_rest;
    ins_next          = ins;
    adding_next       = adding;
    item_next         = item;
    count_next        = count;
    done_next         = 1'b0;
    status_next       = status;
    ran_id_next       = ran_id;
    ran_priority_next = ran_priority;
    used_time_next    = used_time;
    completed_next    = completed;
    we                = 1'b0;
    waddr             = '0;
    wdata             = item;
    re                = 1'b0;
    raddr             = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          status_next       = ST_OK;
          ran_id_next       = '0;
          ran_priority_next = '0;
          used_time_next    = '0;
          completed_next    = 1'b0;
          item_next         = new_item;
          adding_next       = (kind == KIND_ADD);
          if (kind == KIND_ADD) begin
            if (slices_needed == 8'd0) begin
              status_next = ST_ZERO;
              done_next   = 1'b1;
            end else if (count >= CNT_W'(QUEUE_DEPTH)) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
            end else if (count == '0) begin
              we         = 1'b1;
              waddr      = '0;
              wdata      = new_item;
              count_next = count + CNT_W'(1);
              done_next  = 1'b1;
            end else begin
              re         = 1'b1;
              raddr      = IDX_W'(count - CNT_W'(1));
              k_next     = IDX_W'(count);
              state_next = S_INS;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              done_next   = 1'b1;
            end else begin
              re          = 1'b1;
              raddr       = '0;
              n_rest_next = IDX_W'(count - CNT_W'(1));
              state_next  = S_HEAD;
            end
          end
        end
      end

      S_HEAD: begin
        ran_id_next       = rdata.id;
        ran_priority_next = rdata.prio;
        used_time_next    = upd.used;
        item_next         = upd;
        k_next            = '0;
        if (upd.used == rdata.need) begin
          completed_next = 1'b1;
          count_next     = count - CNT_W'(1);
          ins_next       = 1'b0;
          if (n_rest == '0) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            re         = 1'b1;
            raddr      = IDX_W'(1);
            state_next = S_FWD;
          end
        end else begin
          ins_next = 1'b1;
          if (n_rest == '0) begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = upd;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            re         = 1'b1;
            raddr      = IDX_W'(1);
            state_next = S_FWD;
          end
        end
      end

      S_FWD: begin
        we    = 1'b1;
        waddr = k;
        if (ins && !(rdata.prio > item.prio)) begin
          wdata      = item;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          wdata = rdata;
          if (k + IDX_W'(1) == n_rest) begin
            if (ins) begin
              k_next     = k + IDX_W'(1);
              state_next = S_PUT;
            end else begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            re     = 1'b1;
            raddr  = IDX_W'(k + 2);
            k_next = k + IDX_W'(1);
          end
        end
      end

      S_INS: begin
        we    = 1'b1;
        waddr = k;
        if (rdata.prio > item.prio) begin
          wdata      = item;
          count_next = count + CNT_W'(1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          wdata = rdata;
          if (k == IDX_W'(1)) begin
            k_next     = '0;
            state_next = S_PUT;
          end else begin
            re     = 1'b1;
            raddr  = IDX_W'(k - 2);
            k_next = k - IDX_W'(1);
          end
        end
      end

      S_PUT: begin
        we    = 1'b1;
        waddr = k;
        wdata = item;
        if (adding) begin
          count_next = count + CNT_W'(1);
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k            <= k_next;
    n_rest       <= n_rest_next;
    ins          <= ins_next;
    adding       <= adding_next;
    item         <= item_next;
    status       <= status_next;
    ran_id       <= ran_id_next;
    ran_priority <= ran_priority_next;
    used_time    <= used_time_next;
    completed    <= completed_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item neither busy nor done");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> count == '0)
    else $error("empty status with entries queued");

  a_completed_ok: assert property (@(posedge clk) disable iff (rst)
    done && completed |-> status == ST_OK)
    else $error("completion flagged on rejected item");

endmodule
